>>> src/hpt_pkg.sv
// shared types and constants for the 2d homogeneous point transform
// no dependencies
package hpt_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QBITS = 32;
  // cycles from an accepted request to its result strobe
  localparam int unsigned LATENCY = 2 + 1 + QBITS + 1;

  // register indexes
  localparam logic [2:0] REG_X_GAIN = 3'd0;
  localparam logic [2:0] REG_X_OFF  = 3'd1;
  localparam logic [2:0] REG_Y_GAIN = 3'd2;
  localparam logic [2:0] REG_Y_OFF  = 3'd3;
  localparam logic [2:0] REG_W_GAIN = 3'd4;
  localparam logic [2:0] REG_W_OFF  = 3'd5;

  // register reset values (identity matrix)
  localparam logic [63:0] X_GAIN_RST = 64'h0001_0000_0000_0000;
  localparam logic [31:0] X_OFF_RST  = 32'h0000_0000;
  localparam logic [63:0] Y_GAIN_RST = 64'h0000_0000_0001_0000;
  localparam logic [31:0] Y_OFF_RST  = 32'h0000_0000;
  localparam logic [63:0] W_GAIN_RST = 64'h0000_0000_0000_0000;
  localparam logic [31:0] W_OFF_RST  = 32'h0001_0000;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  // one divider stage: both coordinates share the divisor
  typedef struct packed {
    logic        zero;
    logic        neg_x;
    logic        neg_y;
    logic        ovf_x;
    logic        ovf_y;
    logic [63:0] dvs;
    logic [63:0] rem_x;
    logic [63:0] rem_y;
    logic [31:0] qd_x;
    logic [31:0] qd_y;
  } div_stage_t;

endpackage

>>> src/hpt_lin.sv
// one matrix column: floor((a*ma + b*mb) / 2^frac) + mc over two register stages
// depends on hpt_pkg
module hpt_lin import hpt_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic [63:0]        pair_i,
  input  logic [31:0]        off_i,
  output logic signed [63:0] res_o
);

  logic signed [63:0] p1_q, p2_q;
  logic signed [65:0] sum;
  logic signed [65:0] shr;
  logic signed [63:0] res_d, res_q;

  // stage 1: products
  always_ff @(posedge clk_i) begin
    p1_q <= a_i * $signed(pair_i[63:32]);
    p2_q <= b_i * $signed(pair_i[31:0]);
  end

  // stage 2: exact sum, floor shift, offset
  always_comb begin
    sum   = {{2{p1_q[63]}}, p1_q} + {{2{p2_q[63]}}, p2_q};
    shr   = sum >>> FracBits;
    res_d = shr[63:0] + {{32{off_i[31]}}, off_i};
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> src/hpt_div_step.sv
// one restoring division step for both coordinates, registered
// depends on hpt_pkg
module hpt_div_step import hpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  div_stage_t st_i,
  output logic       valid_o,
  output div_stage_t st_o
);

  logic [64:0] sh_x, sh_y, dif_x, dif_y;
  logic        ge_x, ge_y;
  div_stage_t  st_d, st_q;
  logic        valid_q;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    sh_x  = {st_i.rem_x, st_i.qd_x[31]};
    sh_y  = {st_i.rem_y, st_i.qd_y[31]};
    dif_x = sh_x - {1'b0, st_i.dvs};
    dif_y = sh_y - {1'b0, st_i.dvs};
    ge_x  = sh_x >= {1'b0, st_i.dvs};
    ge_y  = sh_y >= {1'b0, st_i.dvs};
    st_d       = st_i;
    st_d.rem_x = ge_x ? dif_x[63:0] : sh_x[63:0];
    st_d.rem_y = ge_y ? dif_y[63:0] : sh_y[63:0];
    st_d.qd_x  = {st_i.qd_x[30:0], ge_x};
    st_d.qd_y  = {st_i.qd_y[30:0], ge_y};
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

>>> src/homogeneous_point_transform_2d.sv
// top level: config registers, column units, divider pipeline, saturation
// depends on hpt_pkg, hpt_lin, hpt_div_step
//
// channel   direction  handshake                 payload
// request   in         start_i && !busy_o        in_x_i, in_y_i
// result    out        valid_o, one cycle        out_x_o, out_y_o, status_o
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// a request is taken every cycle; busy_o stays low
// each result passes the column units' product and sum registers, the divider setup register,
// one divider stage per quotient bit and the saturation register before valid_o
// reset clears the pipeline valid bits and loads the identity matrix
// the receiver cannot stall, so nothing ever holds in the pipeline
module homogeneous_point_transform_2d import hpt_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  output logic               valid_o,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic [1:0]         status_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);

  logic [63:0] x_gain_q, y_gain_q, w_gain_q;
  logic [31:0] x_off_q, y_off_q, w_off_q;
  logic [1:0]  lin_vld_q;
  logic signed [63:0] xp, yp, ww;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_gain_q <= X_GAIN_RST;
      x_off_q  <= X_OFF_RST;
      y_gain_q <= Y_GAIN_RST;
      y_off_q  <= Y_OFF_RST;
      w_gain_q <= W_GAIN_RST;
      w_off_q  <= W_OFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X_GAIN: x_gain_q <= cfg_data_i;
        REG_X_OFF:  x_off_q  <= cfg_data_i[31:0];
        REG_Y_GAIN: y_gain_q <= cfg_data_i;
        REG_Y_OFF:  y_off_q  <= cfg_data_i[31:0];
        REG_W_GAIN: w_gain_q <= cfg_data_i;
        REG_W_OFF:  w_off_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // column units
  hpt_lin #(.FracBits(FracBits)) u_lin_x (
    .clk_i, .a_i(in_x_i), .b_i(in_y_i), .pair_i(x_gain_q), .off_i(x_off_q), .res_o(xp)
  );
  hpt_lin #(.FracBits(FracBits)) u_lin_y (
    .clk_i, .a_i(in_x_i), .b_i(in_y_i), .pair_i(y_gain_q), .off_i(y_off_q), .res_o(yp)
  );
  hpt_lin #(.FracBits(FracBits)) u_lin_w (
    .clk_i, .a_i(in_x_i), .b_i(in_y_i), .pair_i(w_gain_q), .off_i(w_off_q), .res_o(ww)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_vld_q <= '0;
    end else begin
      lin_vld_q <= {lin_vld_q[0], start_i};
    end
  end

  // divider setup: magnitudes, dividends, signs, zero and early overflow checks
  logic [63:0] mag_x, mag_y, mag_w, dvd_x, dvd_y;
  div_stage_t  prep_d;
  div_stage_t  st   [QBITS+1];
  logic        vld  [QBITS+1];

  always_comb begin
    mag_x = xp[63] ? 64'd0 - xp : xp;
    mag_y = yp[63] ? 64'd0 - yp : yp;
    mag_w = ww[63] ? 64'd0 - ww : ww;
    dvd_x = mag_x << FracBits;
    dvd_y = mag_y << FracBits;
    prep_d.zero  = (ww == 64'sd0);
    prep_d.neg_x = xp[63] ^ ww[63];
    prep_d.neg_y = yp[63] ^ ww[63];
    prep_d.ovf_x = {32'd0, dvd_x[63:32]} >= mag_w;
    prep_d.ovf_y = {32'd0, dvd_y[63:32]} >= mag_w;
    prep_d.dvs   = mag_w;
    prep_d.rem_x = {32'd0, dvd_x[63:32]};
    prep_d.rem_y = {32'd0, dvd_y[63:32]};
    prep_d.qd_x  = dvd_x[31:0];
    prep_d.qd_y  = dvd_y[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= lin_vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    st[0] <= prep_d;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QBITS; k++) begin : g_div
    hpt_div_step u_step (
      .clk_i, .rst_ni,
      .valid_i(vld[k]), .st_i(st[k]),
      .valid_o(vld[k+1]), .st_o(st[k+1])
    );
  end

  // sign, saturation and status
  div_stage_t  fin;
  logic        sat_x, sat_y;
  logic [31:0] res_x, res_y;
  logic [31:0] ox_d, oy_d, ox_q, oy_q;
  logic [1:0]  stat_d, stat_q;
  logic        vout_q;

  always_comb begin
    fin = st[QBITS];
    if (fin.neg_x) begin
      sat_x = fin.ovf_x || (fin.qd_x > 32'h8000_0000);
      res_x = sat_x ? 32'h8000_0000 : 32'd0 - fin.qd_x;
    end else begin
      sat_x = fin.ovf_x || fin.qd_x[31];
      res_x = sat_x ? 32'h7FFF_FFFF : fin.qd_x;
    end
    if (fin.neg_y) begin
      sat_y = fin.ovf_y || (fin.qd_y > 32'h8000_0000);
      res_y = sat_y ? 32'h8000_0000 : 32'd0 - fin.qd_y;
    end else begin
      sat_y = fin.ovf_y || fin.qd_y[31];
      res_y = sat_y ? 32'h7FFF_FFFF : fin.qd_y;
    end
    if (fin.zero) begin
      ox_d   = '0;
      oy_d   = '0;
      stat_d = ST_DIV0;
    end else begin
      ox_d   = res_x;
      oy_d   = res_y;
      stat_d = (sat_x || sat_y) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else begin
      vout_q <= vld[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    stat_q <= stat_d;
  end

  assign valid_o  = vout_q;
  assign out_x_o  = ox_q;
  assign out_y_o  = oy_q;
  assign status_o = stat_q;

endmodule

>>> src/hpt_checker.sv
// port-level checks for the point transform, bound to the top level
// depends on hpt_pkg and homogeneous_point_transform_2d
module hpt_checker import hpt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        valid_o,
  input logic [31:0] out_x_o,
  input logic [31:0] out_y_o,
  input logic [1:0]  status_o
);

  // every result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, LATENCY))
    else $error("result without matching request");

  // zero w gives zero coordinates
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_DIV0) |-> (out_x_o == 32'd0 && out_y_o == 32'd0))
    else $error("divide error with nonzero output");

  // only defined status codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == ST_OK || status_o == ST_SAT || status_o == ST_DIV0))
    else $error("bad status code");

  // no result right out of reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !valid_o)
    else $error("result strobe during reset");

endmodule

bind homogeneous_point_transform_2d hpt_checker u_hpt_checker (
  .clk_i, .rst_ni, .start_i, .valid_o, .out_x_o, .out_y_o, .status_o
);

>>> sim/tb.sv
// testbench for homogeneous_point_transform_2d: directed and random points under several matrices
// depends on hpt_pkg and the homogeneous_point_transform_2d rtl
module tb;
  import hpt_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned WDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [1:0]         st;
  } point_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [31:0] in_x_i = '0;
  logic signed [31:0] in_y_i = '0;
  logic               valid_o;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic [1:0]         status_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [63:0]        cfg_data_i = '0;

  // local copy of the matrix registers
  logic [63:0] mx_gain, my_gain, mw_gain;
  logic [31:0] mx_off, my_off, mw_off;

  point_res_t pending_points[$];
  int         mismatch_cnt = 0;
  int         request_cnt = 0;
  int         result_cnt = 0;
  int         sat_cnt = 0;
  int         div0_cnt = 0;
  int         idle_cycles = 0;
  bit         idle_on = 1'b1;

  homogeneous_point_transform_2d dut (.*);

  always #5 clk_i = ~clk_i;

  // floor((a*ma + b*mb) / 2^FB) + mc on exact products
  function automatic logic signed [127:0] lin_term(logic signed [31:0] a,
      logic signed [31:0] b, logic [63:0] pair, logic [31:0] off);
    logic signed [127:0] acc;
    acc = 128'(a) * 128'($signed(pair[63:32])) + 128'(b) * 128'($signed(pair[31:0]));
    return (acc >>> FB) + 128'($signed(off));
  endfunction

  // (num << FB) / w toward zero, saturated
  function automatic logic [31:0] scaled_quot(logic signed [127:0] num,
      logic signed [127:0] w, inout bit sat);
    logic [127:0] mn, mw, q;
    bit neg;
    mn = num < 0 ? -num : num;
    mw = w < 0 ? -w : w;
    q = (mn << FB) / mw;
    neg = (num < 0) != (w < 0);
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        q = 128'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 128'h7fff_ffff) begin
      sat = 1'b1;
      q = 128'h7fff_ffff;
    end
    return q[31:0];
  endfunction

  function automatic point_res_t project_point(logic signed [31:0] x, logic signed [31:0] y);
    logic signed [127:0] xp, yp, w;
    point_res_t r;
    bit sat;
    sat = 1'b0;
    xp = lin_term(x, y, mx_gain, mx_off);
    yp = lin_term(x, y, my_gain, my_off);
    w = lin_term(x, y, mw_gain, mw_off);
    if (w == 0) begin
      r = '{px: '0, py: '0, st: ST_DIV0};
    end else begin
      r.px = scaled_quot(xp, w, sat);
      r.py = scaled_quot(yp, w, sat);
      r.st = sat ? ST_SAT : ST_OK;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_cnt++;
  endtask

  // send one request, with random idle bursts when enabled
  task automatic send_point(logic [31:0] x, logic [31:0] y);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_x_i <= x;
    in_y_i <= y;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_points.push_back(project_point(x, y));
    request_cnt++;
  endtask

  task automatic go_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_X_GAIN: mx_gain = data;
      REG_X_OFF:  mx_off = data[31:0];
      REG_Y_GAIN: my_gain = data;
      REG_Y_OFF:  my_off = data[31:0];
      REG_W_GAIN: mw_gain = data;
      REG_W_OFF:  mw_off = data[31:0];
      default: ;
    endcase
  endtask

  task automatic load_matrix(logic [63:0] xg, logic [31:0] xo, logic [63:0] yg,
      logic [31:0] yo, logic [63:0] wg, logic [31:0] wo);
    write_reg(REG_X_GAIN, xg);
    write_reg(REG_X_OFF, {32'hdead_beef, xo});
    write_reg(REG_Y_GAIN, yg);
    write_reg(REG_Y_OFF, {32'hffff_ffff, yo});
    write_reg(REG_W_GAIN, wg);
    write_reg(REG_W_OFF, {32'h1234_5678, wo});
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  // identity at reset, extremes, zero w, saturation, w from the point and writes to unused indexes
  task automatic test_directed();
    send_point(32'h0001_0000, 32'hffff_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h0, 32'h0);
    go_idle();
    // w = 0 everywhere: division error
    load_matrix(X_GAIN_RST, 32'h0, Y_GAIN_RST, 32'h0, 64'h0, 32'h0);
    send_point(32'h1234_5678, 32'h8765_4321);
    go_idle();
    // tiny w: saturation both signs
    load_matrix(64'h7fff_ffff_8000_0000, 32'h7fff_ffff, 64'h8000_0000_7fff_ffff,
                32'h8000_0000, 64'h0, 32'h0000_0001);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h0000_0001, 32'hffff_ffff);
    go_idle();
    // w driven by the point, fraction that floors to zero
    load_matrix(X_GAIN_RST, 32'h0001_0000, Y_GAIN_RST, 32'hffff_0000,
                64'h0000_0001_0000_0000, 32'h0);
    send_point(32'h0000_ffff, 32'h5);
    send_point(32'hffff_ffff, 32'h5);
    send_point(32'h0001_0000, 32'h7);
    send_point(32'h8000_0000, 32'h7fff_ffff);
    go_idle();
    // writes to unused indexes change nothing
    write_reg(3'd6, 64'hffff_ffff_ffff_ffff);
    write_reg(3'd7, 64'h0);
    send_point(32'h0002_0000, 32'h3);
    go_idle();
  endtask

  // random points under a series of random and extreme matrices
  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      case (p % 4)
        0: load_matrix({$urandom(), $urandom()}, $urandom(), {$urandom(), $urandom()},
                       $urandom(), {$urandom(), $urandom()}, $urandom());
        1: load_matrix({$urandom_range(0, 32'h3_0000) - 32'h1_8000,
                        $urandom_range(0, 32'h3_0000) - 32'h1_8000},
                       $urandom(), {$urandom(), $urandom()}, $urandom(),
                       {16'h0, 16'($urandom()), 16'h0, 16'($urandom())},
                       $urandom_range(1, 32'h4_0000));
        2: load_matrix({2{32'h8000_0000}}, 32'h8000_0000, {2{32'h7fff_ffff}},
                       32'h7fff_ffff, {$urandom(), $urandom()}, $urandom());
        default: load_matrix(X_GAIN_RST, $urandom(), Y_GAIN_RST, $urandom(),
                             {2{32'h0}}, 32'h0001_0000);
      endcase
      for (int i = 0; i < per_phase; i++) send_point(rand_coord(), rand_coord());
      go_idle();
    end
  endtask

  // back to back requests, no idling
  task automatic test_streaming(int n);
    idle_on = 1'b0;
    load_matrix({$urandom(), $urandom()}, $urandom(), {$urandom(), $urandom()},
                $urandom(), {$urandom(), $urandom()}, $urandom());
    for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord());
    go_idle();
  endtask

  // result checker
  always @(posedge clk_i) begin
    point_res_t want;
    if (rst_ni && valid_o) begin
      result_cnt++;
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected result", out_x_o, 32'h0);
      end else begin
        want = pending_points.pop_front();
        if (out_x_o !== want.px) report_mismatch("out_x", out_x_o, want.px);
        if (out_y_o !== want.py) report_mismatch("out_y", out_y_o, want.py);
        if (status_o !== want.st) report_mismatch("status", 32'(status_o), 32'(want.st));
        if (want.st == ST_SAT) sat_cnt++;
        if (want.st == ST_DIV0) div0_cnt++;
      end
    end
  end

  // watchdog on cycles with no request, no result and no config write
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    mx_gain = X_GAIN_RST;
    mx_off = X_OFF_RST;
    my_gain = Y_GAIN_RST;
    my_off = Y_OFF_RST;
    mw_gain = W_GAIN_RST;
    mw_off = W_OFF_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(8, 65);
    test_streaming(110);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("%0d requests, %0d results (%0d saturated, %0d zero w) over 13 matrices",
             request_cnt, result_cnt, sat_cnt, div0_cnt);
    if (mismatch_cnt == 0 && pending_points.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, pending_points.size());
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/hpt_pkg.sv
src/hpt_lin.sv
src/hpt_div_step.sv
src/homogeneous_point_transform_2d.sv
src/hpt_checker.sv
sim/tb.sv
